[hdl/stq_pkg.sv]
// stq_pkg: shared types and codes for the sorted timer expiry queue.
// No dependencies; imported by sorted_timer_expiry_queue, stq_alu and the bench.
`default_nettype none

package stq_pkg;

  localparam int TW       = 32;
  localparam int SIGN_BIT = TW - 1;
  localparam int IDW      = 4;

  typedef enum logic [1:0] {
    FN_TICK      = 2'd0,
    FN_START_ABS = 2'd1,
    FN_START_REL = 2'd2,
    FN_STOP      = 2'd3
  } func_e;

  typedef enum logic {
    KIND_ACK     = 1'b0,
    KIND_EXPIRED = 1'b1
  } kind_e;

  typedef enum logic {
    ST_OK    = 1'b0,
    ST_ARMED = 1'b1
  } status_e;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_e;

  typedef struct packed {
    alu_op_e         op;
    logic [TW-1:0]   a;
    logic [TW-1:0]   b;
  } alu_req_t;

  typedef struct packed {
    kind_e           kind;
    status_e         status;
    logic [IDW-1:0]  id;
  } result_t;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SEARCH  = 7'b0000010,
    S_SHIFT   = 7'b0000100,
    S_FIND    = 7'b0001000,
    S_COMPACT = 7'b0010000,
    S_HEADRD  = 7'b0100000,
    S_HEAD    = 7'b1000000
  } state_e;

endpackage

`default_nettype wire

[hdl/stq_ifs.sv]
// Valid/ready channel interfaces for the timer queue request and result transfers.
// No dependencies.
`default_nettype none

interface stq_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  timer_id;
  logic [31:0] time_value;

  modport source (output valid, func, timer_id, time_value, input ready);
  modport sink   (input valid, func, timer_id, time_value, output ready);
endinterface

interface stq_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        status;
  logic [3:0]  expired_id;
  logic [31:0] now;
  logic        last;

  modport source (output valid, kind, status, expired_id, now, last, input ready);
  modport sink   (input valid, kind, status, expired_id, now, last, output ready);
endinterface

`default_nettype wire

[hdl/sorted_timer_expiry_queue.sv]
// Sorted timer expiry queue: wrapping tick counter plus an expiry-sorted timer list in RAM.
// A tick goes straight to its acknowledgement; a start or stop walks the list first (a refused
// start or an unarmed stop does not), and each expired timer then costs a further list walk.
// Throughput: one item at a time, one RAM entry per walk cycle.
// Reset clears the counter, armed flags and queue length; the list RAM is not cleared.
// Depends on stq_pkg, stq_ifs, stq_ram, stq_alu.
`default_nettype none

module sorted_timer_expiry_queue import stq_pkg::*; #(
  parameter int TIMERS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stq_req_if.sink   req_i,
  stq_rsp_if.source rsp_o
);

  localparam int AW = $clog2(TIMERS);
  localparam int CW = $clog2(TIMERS + 1);
  localparam int EW = AW + TW;
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);

  typedef struct packed {
    logic [AW-1:0] slot;
    logic [TW-1:0] when;
  } entry_t;

  state_e             state_q, state_d;
  logic [TW-1:0]      now_q, now_d;
  logic [CW-1:0]      len_q, len_d;
  logic [TIMERS-1:0]  armed_q, armed_d;
  logic               chk_q, chk_d;
  logic [AW-1:0]      id_q, id_d;
  logic [TW-1:0]      when_q, when_d;
  logic [CW-1:0]      i_q, i_d;
  entry_t             carry_q, carry_d;
  result_t            pend_q, pend_d;

  logic               rsp_valid_q, rsp_valid_d;
  result_t            rsp_res_q, rsp_res_d;
  logic [TW-1:0]      rsp_now_q, rsp_now_d;
  logic               rsp_last_q, rsp_last_d;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  entry_t             ram_wdata, rd_entry;
  logic [EW-1:0]      ram_rdata;

  alu_req_t           alu_req;
  logic [TW-1:0]      alu_res;

  logic               in_range, armed_hit, out_free, due;
  logic [AW-1:0]      req_slot;
  func_e              req_func;

  stq_ram #(.W(EW), .DEPTH(TIMERS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stq_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  assign rd_entry  = ram_rdata;
  assign req_func  = func_e'(req_i.func);
  assign req_slot  = AW'(req_i.timer_id);
  assign in_range  = ({28'd0, req_i.timer_id} < 32'(TIMERS));
  assign armed_hit = in_range && armed_q[req_slot];
  assign out_free  = !rsp_valid_q || rsp_o.ready;
  assign due       = chk_q && (len_q != '0) && !alu_res[SIGN_BIT];

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    len_d      = len_q;
    armed_d    = armed_q;
    chk_d      = chk_q;
    id_d       = id_q;
    when_d     = when_q;
    i_d        = i_q;
    carry_d    = carry_q;
    pend_d     = pend_q;
    ram_we     = 1'b0;
    ram_waddr  = i_q[AW-1:0];
    ram_wdata  = '{slot: id_q, when: when_q};
    ram_re     = 1'b0;
    ram_raddr  = AW'(i_q + ONE);
    alu_req    = '{op: ALU_SUB, a: when_q, b: rd_entry.when};
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_res_d  = rsp_res_q;
    rsp_now_d  = rsp_now_q;
    rsp_last_d = rsp_last_q;

    unique case (state_q)
      S_IDLE: begin
        alu_req = '{op: ALU_ADD, a: now_q,
                    b: (req_func == FN_TICK) ? TW'(1) : req_i.time_value};
        if (req_i.valid) begin
          id_d   = req_slot;
          chk_d  = (req_func != FN_STOP);
          pend_d = '{kind: KIND_ACK, status: ST_OK, id: '0};
          i_d    = '0;
          when_d = (req_func == FN_START_ABS) ? req_i.time_value : alu_res;
          state_d = S_HEADRD;
          unique case (req_func)
            FN_TICK: now_d = alu_res;
            FN_START_ABS, FN_START_REL: begin
              if (armed_hit) begin
                pend_d.status = ST_ARMED;
              end else if (in_range) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = S_SEARCH;
              end
            end
            FN_STOP: begin
              if (armed_hit) begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = S_FIND;
              end
            end
            default: state_d = S_HEADRD;
          endcase
        end
      end

      S_SEARCH: begin
        if (i_q == len_q) begin
          ram_we       = 1'b1;
          len_d        = len_q + ONE;
          armed_d[id_q] = 1'b1;
          state_d      = S_HEADRD;
        end else if (alu_res[SIGN_BIT]) begin
          ram_we       = 1'b1;
          carry_d      = rd_entry;
          i_d          = i_q + ONE;
          ram_re       = 1'b1;
          armed_d[id_q] = 1'b1;
          state_d      = S_SHIFT;
        end else begin
          i_d    = i_q + ONE;
          ram_re = 1'b1;
        end
      end

      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_wdata = carry_q;
        if (i_q == len_q) begin
          len_d   = len_q + ONE;
          state_d = S_HEADRD;
        end else begin
          carry_d = rd_entry;
          i_d     = i_q + ONE;
          ram_re  = 1'b1;
        end
      end

      S_FIND: begin
        ram_re = 1'b1;
        if (rd_entry.slot == id_q) begin
          armed_d[id_q] = 1'b0;
          state_d       = S_COMPACT;
        end else begin
          i_d = i_q + ONE;
        end
      end

      S_COMPACT: begin
        if ((i_q + ONE) == len_q) begin
          len_d   = len_q - ONE;
          state_d = S_HEADRD;
        end else begin
          ram_we    = 1'b1;
          ram_wdata = rd_entry;
          i_d       = i_q + ONE;
          ram_re    = 1'b1;
          ram_raddr = AW'(i_q + TWO);
        end
      end

      S_HEADRD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
        state_d   = S_HEAD;
      end

      S_HEAD: begin
        alu_req = '{op: ALU_SUB, a: now_q, b: rd_entry.when};
        if (out_free) begin
          rsp_valid_d = 1'b1;
          rsp_res_d   = pend_q;
          rsp_now_d   = now_q;
          rsp_last_d  = !due;
          if (due) begin
            pend_d = '{kind: KIND_EXPIRED, status: ST_OK, id: IDW'(rd_entry.slot)};
            armed_d[rd_entry.slot] = 1'b0;
            i_d       = '0;
            ram_re    = 1'b1;
            ram_raddr = AW'(ONE);
            state_d   = S_COMPACT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      len_q       <= '0;
      armed_q     <= '0;
      chk_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      len_q       <= len_d;
      armed_q     <= armed_d;
      chk_q       <= chk_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q       <= id_d;
    when_q     <= when_d;
    i_q        <= i_d;
    carry_q    <= carry_d;
    pend_q     <= pend_d;
    rsp_res_q  <= rsp_res_d;
    rsp_now_q  <= rsp_now_d;
    rsp_last_q <= rsp_last_d;
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.kind       = rsp_res_q.kind;
  assign rsp_o.status     = rsp_res_q.status;
  assign rsp_o.expired_id = rsp_res_q.id;
  assign rsp_o.now        = rsp_now_q;
  assign rsp_o.last       = rsp_last_q;

  // armed flags and list length agree between items
  a_len_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(armed_q) == int'(len_q)))
    else $error("queue length differs from armed count");

  a_len_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(len_q) <= TIMERS))
    else $error("queue length beyond capacity");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEARCH || state_q == S_SHIFT) |-> (i_q <= len_q))
    else $error("insert walk past list end");

  a_compact_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMPACT || state_q == S_FIND) |-> (i_q < len_q))
    else $error("removal walk past list end");

endmodule

`default_nettype wire

[hdl/stq_ram.sv]
// stq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stq_ram #(
  parameter int W     = 36,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [W-1:0]             wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/stq_alu.sv]
// stq_alu: shared 32-bit add/subtract unit; subtract sign gives the wrap-aware compare.
// Depends on stq_pkg.
`default_nettype none

module stq_alu import stq_pkg::*; (
  input  alu_req_t      req_i,
  output logic [TW-1:0] res_o
);

  always_comb begin
    unique case (req_i.op)
      ALU_ADD: res_o = req_i.a + req_i.b;
      ALU_SUB: res_o = req_i.a - req_i.b;
      default: res_o = req_i.a - req_i.b;
    endcase
  end

endmodule

`default_nettype wire

[sim/tb.sv]
// tb: self-checking bench for sorted_timer_expiry_queue, driving valid/ready transfers.
// Predicts acks and expirations with a behavioral copy of the sorted timer list.
// Depends on stq_pkg, stq_ifs and the block's RTL.

module tb;
  import stq_pkg::*;

  localparam int NTIMERS = 16;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    kind_e       kind;
    status_e     status;
    logic [3:0]  id;
    logic [31:0] now;
    logic        last;
  } timer_rsp_t;

  typedef struct packed {
    func_e       fn;
    logic [3:0]  id;
    logic [31:0] tv;
    logic        fixed;
    status_e     st;
    logic [31:0] now;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  stq_req_if req_if();
  stq_rsp_if rsp_if();

  sorted_timer_expiry_queue #(.TIMERS(NTIMERS)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // predicted state
  logic [31:0] tick_now;
  logic [31:0] due_at [NTIMERS];
  bit          is_armed [NTIMERS];
  int          sched_q [$];
  timer_rsp_t  pending_q [$];

  int errors;
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_req;
  int n_items, n_expired, n_refused, n_stops;

  stim_row_t rows [20];

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic bit is_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  task automatic push_rsp(kind_e k, status_e s, logic [3:0] id);
    timer_rsp_t r;
    r.kind = k;
    r.status = s;
    r.id = id;
    r.now = tick_now;
    r.last = 1'b1;
    if (pending_q.size() > 0 && k == KIND_EXPIRED)
      pending_q[pending_q.size() - 1].last = 1'b0;
    pending_q.push_back(r);
  endtask

  task automatic apply_timer_item(func_e fn, logic [3:0] id, logic [31:0] tv);
    status_e st;
    logic [31:0] when;
    int pos;
    st = ST_OK;
    n_items++;
    case (fn)
      FN_TICK: begin
        tick_now = tick_now + 1;
      end
      FN_START_ABS, FN_START_REL: begin
        if (is_armed[id]) begin
          st = ST_ARMED;
          n_refused++;
        end else begin
          when = (fn == FN_START_ABS) ? tv : tick_now + tv;
          pos = 0;
          while (pos < sched_q.size() && !is_before(when, due_at[sched_q[pos]]))
            pos++;
          sched_q.insert(pos, id);
          due_at[id] = when;
          is_armed[id] = 1'b1;
        end
      end
      FN_STOP: begin
        n_stops++;
        if (is_armed[id]) begin
          foreach (sched_q[i])
            if (sched_q[i] == id) begin
              sched_q.delete(i);
              break;
            end
          is_armed[id] = 1'b0;
        end
      end
    endcase
    push_rsp(KIND_ACK, st, 4'd0);
    if (fn != FN_STOP) begin
      while (sched_q.size() > 0 && !is_before(tick_now, due_at[sched_q[0]])) begin
        is_armed[sched_q[0]] = 1'b0;
        push_rsp(KIND_EXPIRED, ST_OK, sched_q[0]);
        sched_q.delete(0);
        n_expired++;
      end
    end
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // one transfer on the request channel; optional typed ack overrides the prediction
  task automatic send_item(func_e fn, logic [3:0] id, logic [31:0] tv,
                           logic fixed = 1'b0, status_e st = ST_OK,
                           logic [31:0] now_w = '0);
    int gap;
    int base;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid = 1'b1;
    req_if.func = fn;
    req_if.timer_id = id;
    req_if.time_value = tv;
    do @(posedge clk_i); while (!req_if.ready);
    base = pending_q.size();
    apply_timer_item(fn, id, tv);
    if (fixed) begin
      pending_q[base].status = st;
      pending_q[base].now = now_w;
    end
    @(negedge clk_i);
  endtask

  task automatic send_random();
    int r;
    logic [3:0] id;
    logic [31:0] tv;
    func_e fn;
    r = $urandom_range(99);
    id = 4'($urandom_range(15));
    if (r < 35) begin
      fn = FN_TICK;
      tv = $urandom;
    end else if (r < 62) begin
      fn = FN_START_REL;
      tv = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(24));
    end else if (r < 80) begin
      fn = FN_START_ABS;
      tv = ($urandom_range(7) == 0) ? $urandom : tick_now + $urandom_range(30) - 5;
    end else begin
      fn = FN_STOP;
      tv = $urandom;
    end
    send_item(fn, id, tv);
  endtask

  task automatic drain();
    req_if.valid = 1'b0;
    while (pending_q.size() > 0) @(negedge clk_i);
  endtask

  // receiver: random stalls plus one long hold-off on request
  always @(negedge clk_i) begin : rsp_drive
    int hold_left;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready = 1'b0;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : rsp_check
    timer_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected transfer, now", rsp_if.now, '0);
      end else begin
        want = pending_q.pop_front();
        if (rsp_if.kind != want.kind) report("kind", rsp_if.kind, want.kind);
        if (rsp_if.status != want.status) report("status", rsp_if.status, want.status);
        if (rsp_if.expired_id != want.id) report("expired_id", rsp_if.expired_id, want.id);
        if (rsp_if.now != want.now) report("now", rsp_if.now, want.now);
        if (rsp_if.last != want.last) report("last", rsp_if.last, want.last);
      end
    end
  end

  initial begin
    rows[0]  = '{FN_TICK,      4'd0,  32'd0,          1'b1, ST_OK,    32'd1};
    rows[1]  = '{FN_STOP,      4'd5,  32'd0,          1'b1, ST_OK,    32'd1};
    rows[2]  = '{FN_START_ABS, 4'd0,  32'hFFFF_FFFF,  1'b1, ST_OK,    32'd1};
    rows[3]  = '{FN_START_REL, 4'd1,  32'd0,          1'b1, ST_OK,    32'd1};
    rows[4]  = '{FN_START_REL, 4'd2,  32'd3,          1'b0, ST_OK,    32'd0};
    rows[5]  = '{FN_START_REL, 4'd2,  32'd5,          1'b1, ST_ARMED, 32'd1};
    rows[6]  = '{FN_START_ABS, 4'd3,  32'd4,          1'b0, ST_OK,    32'd0};
    rows[7]  = '{FN_STOP,      4'd3,  32'hFFFF_FFFF,  1'b0, ST_OK,    32'd0};
    rows[8]  = '{FN_START_ABS, 4'd3,  32'd4,          1'b0, ST_OK,    32'd0};
    rows[9]  = '{FN_START_REL, 4'd7,  32'd2,          1'b0, ST_OK,    32'd0};
    rows[10] = '{FN_TICK,      4'd15, 32'hFFFF_FFFF,  1'b0, ST_OK,    32'd0};
    rows[11] = '{FN_TICK,      4'd0,  32'd0,          1'b0, ST_OK,    32'd0};
    rows[12] = '{FN_TICK,      4'd0,  32'd0,          1'b0, ST_OK,    32'd0};
    rows[13] = '{FN_START_REL, 4'd15, 32'h7FFF_FFFF,  1'b0, ST_OK,    32'd0};
    rows[14] = '{FN_START_ABS, 4'd14, 32'h8000_0004,  1'b0, ST_OK,    32'd0};
    rows[15] = '{FN_START_REL, 4'd9,  32'hFFFF_FFFF,  1'b0, ST_OK,    32'd0};
    rows[16] = '{FN_START_REL, 4'd0,  32'd1,          1'b0, ST_OK,    32'd0};
    rows[17] = '{FN_START_ABS, 4'd0,  32'd0,          1'b1, ST_ARMED, 32'd4};
    rows[18] = '{FN_TICK,      4'd0,  32'd0,          1'b0, ST_OK,    32'd0};
    rows[19] = '{FN_STOP,      4'd15, 32'd0,          1'b1, ST_OK,    32'd5};

    tick_now = '0;
    foreach (is_armed[i]) is_armed[i] = 1'b0;
    foreach (due_at[i]) due_at[i] = '0;
    errors = 0;
    n_items = 0;
    n_expired = 0;
    n_refused = 0;
    n_stops = 0;
    hold_req = 1'b0;
    tx_idle_pct = 14;
    rx_idle_pct = 82;
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.func = FN_TICK;
    req_if.timer_id = '0;
    req_if.time_value = '0;
    rsp_if.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i])
      send_item(rows[i].fn, rows[i].id, rows[i].tv, rows[i].fixed, rows[i].st, rows[i].now);
    drain();

    repeat (150) send_random();
    drain();

    tx_idle_pct = 82;
    rx_idle_pct = 14;
    repeat (150) send_random();
    drain();

    // hold off the receiver so the result path fills, then start every timer to fill the list
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < NTIMERS; i++)
      send_item(FN_START_REL, 4'(i), 32'($urandom_range(40, 5)));
    repeat (134) send_random();
    drain();

    repeat (60) @(posedge clk_i);
    $display("covered %0d items: %0d expirations, %0d refused starts, %0d stops",
             n_items, n_expired, n_refused, n_stops);
    $display("idle mixes 14/82, 82/14 and none, with a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
